@@ src/tmq_pkg.sv @@
// ----------------------------------------------------------------------------
// tmq_pkg: shared types and constants for the tree maze q-learning step
// Node and Q value types, channel payloads, register indexes, reset values and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tmq_pkg;

    // tree shape and field widths
    localparam int NODE_COUNT = 15;
    localparam int FIRST_LEAF = (NODE_COUNT - 1) / 2;
    localparam int NODE_W     = 4;
    localparam int Q_W        = 10;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_VAL_W  = 10;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [Q_W-1:0]    t_q;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE        = 3'd0,
        CFG_DISCOUNT          = 3'd1,
        CFG_EXPLORE_THRESHOLD = 3'd2,
        CFG_GOAL_NODE         = 3'd3,
        CFG_GOAL_REWARD       = 3'd4
    } t_cfg_index;

    // register reset values
    localparam logic [FRAC_W-1:0] RST_LEARN_RATE  = 8'd26;
    localparam logic [FRAC_W-1:0] RST_DISCOUNT    = 8'd230;
    localparam logic [FRAC_W:0]   RST_EXPLORE_THR = 9'd77;
    localparam t_node             RST_GOAL_NODE   = 4'd14;
    localparam t_q                RST_GOAL_REWARD = 10'd1000;

    typedef struct packed {
        t_op              op;
        t_node            load_index;
        t_q               load_value;
        logic [FRAC_W-1:0] explore_draw;
        logic             branch_draw;
    } t_in_item;

    typedef struct packed {
        t_node chosen_node;
        t_q    new_value;
        logic  explored;
        logic  episode_end;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } t_cfg_write;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pick;
        logic fetch;
        logic mul;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic item_is_step;
        logic pos_bad;
    } t_dp_status;

endpackage

@@ src/tmq_chan_if.sv @@
// ----------------------------------------------------------------------------
// tmq_chan_if: valid/ready channel
// Carries one payload per transaction from a source to a sink.
// ----------------------------------------------------------------------------
interface tmq_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/tmq_controller.sv @@
// ----------------------------------------------------------------------------
// tmq_controller: sequencer for load and step transactions
// Steps the datapath through pick, fetch, multiply and commit and owns the
// handshake of the input channel and the valid of the result register.
// ----------------------------------------------------------------------------
module tmq_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tmq_pkg::t_dp_status i_status,
    output tmq_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PICK  = 5'b00010,
        S_FETCH = 5'b00100,
        S_MUL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_status.item_is_step && !i_status.pos_bad) ? S_PICK : S_FIN;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

endmodule

@@ src/tmq_datapath.sv @@
// ----------------------------------------------------------------------------
// tmq_datapath: q table, registers and update arithmetic
// Holds the q table with two read ports, the position, the configuration
// registers, the fixed-point update pipeline and the result register.
// ----------------------------------------------------------------------------
module tmq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  tmq_pkg::t_cfg_write i_cfg_data,
    input  tmq_pkg::t_in_item   i_item_data,
    input  tmq_pkg::t_dp_cmd    i_cmd,
    output tmq_pkg::t_dp_status o_status,
    output tmq_pkg::t_out_item  o_result_data
);

    localparam int IDX_W   = tmq_pkg::NODE_W + 1;
    localparam int RATE_W  = tmq_pkg::FRAC_W + 1;
    localparam int AG_W    = 2 * tmq_pkg::FRAC_W;
    localparam int P1_W    = tmq_pkg::Q_W + RATE_W;
    localparam int P2_W    = AG_W + tmq_pkg::Q_W;
    localparam int SUM_W   = P2_W + 2;
    localparam int GSUM_W  = P1_W + 1;

    // child index, root when the child lies outside the tree
    function automatic tmq_pkg::t_node child_of(input tmq_pkg::t_node node,
                                                input logic right);
        logic [IDX_W-1:0] idx;
        idx = {node, 1'b0} + (right ? IDX_W'(2) : IDX_W'(1));
        child_of = (idx < IDX_W'(tmq_pkg::NODE_COUNT)) ? idx[tmq_pkg::NODE_W-1:0] : '0;
    endfunction

    // configuration registers
    logic [tmq_pkg::FRAC_W-1:0] r_learn_rate;
    logic [tmq_pkg::FRAC_W-1:0] r_discount;
    logic [tmq_pkg::FRAC_W:0]   r_explore_thr;
    tmq_pkg::t_node             r_goal_node;
    tmq_pkg::t_q                r_goal_reward;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate  <= tmq_pkg::RST_LEARN_RATE;
            r_discount    <= tmq_pkg::RST_DISCOUNT;
            r_explore_thr <= tmq_pkg::RST_EXPLORE_THR;
            r_goal_node   <= tmq_pkg::RST_GOAL_NODE;
            r_goal_reward <= tmq_pkg::RST_GOAL_REWARD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_data.index)
                tmq_pkg::CFG_LEARN_RATE:
                    r_learn_rate <= i_cfg_data.value[tmq_pkg::FRAC_W-1:0];
                tmq_pkg::CFG_DISCOUNT:
                    r_discount <= i_cfg_data.value[tmq_pkg::FRAC_W-1:0];
                tmq_pkg::CFG_EXPLORE_THRESHOLD:
                    r_explore_thr <= i_cfg_data.value[tmq_pkg::FRAC_W:0];
                tmq_pkg::CFG_GOAL_NODE:
                    r_goal_node <= i_cfg_data.value[tmq_pkg::NODE_W-1:0];
                tmq_pkg::CFG_GOAL_REWARD:
                    r_goal_reward <= i_cfg_data.value[tmq_pkg::Q_W-1:0];
                default: ;
            endcase
        end
    end

    // latched transaction
    tmq_pkg::t_op               r_op;
    tmq_pkg::t_node             r_load_index;
    tmq_pkg::t_q                r_load_value;
    logic [tmq_pkg::FRAC_W-1:0] r_explore_draw;
    logic                       r_branch_draw;
    logic                       r_bad;

    // step pipeline
    tmq_pkg::t_node             r_pos;
    tmq_pkg::t_node             r_node;
    logic                       r_explored;
    logic [AG_W-1:0]            r_ag;
    tmq_pkg::t_q                r_q;
    tmq_pkg::t_q                r_qc;
    logic [P1_W-1:0]            r_p1;
    logic [P2_W-1:0]            r_p2;
    logic                       r_goal_hit;
    tmq_pkg::t_out_item         r_out;

    // q table
    tmq_pkg::t_q                mem [tmq_pkg::NODE_COUNT];
    logic [tmq_pkg::NODE_COUNT-1:0] r_vld;
    tmq_pkg::t_q                r_rd_a;
    tmq_pkg::t_q                r_rd_b;
    logic                       r_rd_a_vld;
    logic                       r_rd_b_vld;
    tmq_pkg::t_node             rd_a_addr;
    tmq_pkg::t_node             rd_b_addr;
    logic                       wr_en;
    tmq_pkg::t_node             wr_addr;
    tmq_pkg::t_q                wr_data;

    tmq_pkg::t_q                q_a;
    tmq_pkg::t_q                q_b;
    tmq_pkg::t_node             left_node;
    tmq_pkg::t_node             right_node;
    logic                       explore;
    tmq_pkg::t_node             pick_node;
    tmq_pkg::t_q                qmax;
    logic                       node_inner;
    logic                       goal_hit;
    logic [RATE_W-1:0]          keep_rate;
    logic [AG_W-1:0]            mul_a;
    tmq_pkg::t_q                mul_b;
    logic [SUM_W-1:0]           sum_inner;
    logic [GSUM_W-1:0]          sum_goal;
    tmq_pkg::t_q                step_value;
    logic                       load_ok;
    logic                       is_load;

    // unwritten entries read as zero
    assign q_a = r_rd_a_vld ? r_rd_a : '0;
    assign q_b = r_rd_b_vld ? r_rd_b : '0;

    // choose the child: random when exploring, else greedy with ties to the right
    assign left_node  = child_of(r_pos, 1'b0);
    assign right_node = child_of(r_pos, 1'b1);
    assign explore    = {1'b0, r_explore_draw} < r_explore_thr;
    always_comb begin
        if (explore) begin
            pick_node = r_branch_draw ? right_node : left_node;
        end else begin
            pick_node = (q_a > q_b) ? left_node : right_node;
        end
    end

    always_comb begin
        rd_a_addr = left_node;
        rd_b_addr = right_node;
        if (i_cmd.pick) begin
            rd_a_addr = pick_node;
            rd_b_addr = child_of(pick_node, 1'b0);
        end else if (i_cmd.fetch) begin
            rd_a_addr = r_node;
            rd_b_addr = child_of(r_node, 1'b1);
        end
    end

    assign node_inner = r_node < tmq_pkg::NODE_W'(tmq_pkg::FIRST_LEAF);
    assign goal_hit   = !node_inner && (r_node == r_goal_node);
    assign qmax       = (r_qc > q_b) ? r_qc : q_b;
    assign keep_rate  = RATE_W'(1 << tmq_pkg::FRAC_W) - {1'b0, r_learn_rate};

    // one shared multiplier: alpha*reward at the goal leaf, alpha*gamma*qmax otherwise
    assign mul_a = goal_hit ? AG_W'(r_learn_rate) : r_ag;
    assign mul_b = goal_hit ? r_goal_reward : qmax;

    assign sum_inner  = {1'b0, r_p1, {tmq_pkg::FRAC_W{1'b0}}} + SUM_W'(r_p2);
    assign sum_goal   = GSUM_W'(r_p1) + GSUM_W'(r_p2);
    always_comb begin
        if (node_inner) begin
            step_value = sum_inner[2*tmq_pkg::FRAC_W +: tmq_pkg::Q_W];
        end else if (r_goal_hit) begin
            step_value = sum_goal[tmq_pkg::FRAC_W +: tmq_pkg::Q_W];
        end else begin
            step_value = r_q;
        end
    end

    assign is_load = (r_op == tmq_pkg::OP_LOAD);
    assign load_ok = r_load_index < tmq_pkg::NODE_W'(tmq_pkg::NODE_COUNT);
    assign wr_en   = i_cmd.commit && (is_load ? load_ok : !r_bad);
    assign wr_addr = is_load ? r_load_index : r_node;
    assign wr_data = is_load ? r_load_value : step_value;

    always_ff @(posedge i_clk) begin
        r_rd_a     <= mem[rd_a_addr];
        r_rd_b     <= mem[rd_b_addr];
        r_rd_a_vld <= r_vld[rd_a_addr];
        r_rd_b_vld <= r_vld[rd_b_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_pos <= '0;
        end else if (i_cmd.commit) begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (!is_load) begin
                r_pos <= (r_bad || !node_inner) ? '0 : r_node;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op           <= i_item_data.op;
            r_load_index   <= i_item_data.load_index;
            r_load_value   <= i_item_data.load_value;
            r_explore_draw <= i_item_data.explore_draw;
            r_branch_draw  <= i_item_data.branch_draw;
            r_bad          <= o_status.pos_bad;
        end
        if (i_cmd.pick) begin
            r_node     <= pick_node;
            r_explored <= explore;
            r_ag       <= AG_W'(r_learn_rate) * AG_W'(r_discount);
        end
        if (i_cmd.fetch) begin
            r_q  <= q_a;
            r_qc <= q_b;
        end
        if (i_cmd.mul) begin
            r_p1       <= P1_W'(r_q) * P1_W'(keep_rate);
            r_p2       <= P2_W'(mul_a) * P2_W'(mul_b);
            r_goal_hit <= goal_hit;
        end
        if (i_cmd.commit) begin
            if (is_load) begin
                r_out.chosen_node <= r_load_index;
                r_out.new_value   <= load_ok ? r_load_value : '0;
                r_out.explored    <= 1'b0;
                r_out.episode_end <= 1'b0;
            end else if (r_bad) begin
                r_out.chosen_node <= '0;
                r_out.new_value   <= '0;
                r_out.explored    <= 1'b0;
                r_out.episode_end <= 1'b1;
            end else begin
                r_out.chosen_node <= r_node;
                r_out.new_value   <= step_value;
                r_out.explored    <= r_explored;
                r_out.episode_end <= !node_inner;
            end
        end
    end

    assign o_status.item_is_step = (i_item_data.op == tmq_pkg::OP_STEP);
    assign o_status.pos_bad      = r_pos >= tmq_pkg::NODE_W'(tmq_pkg::FIRST_LEAF);
    assign o_result_data         = r_out;

endmodule

@@ src/tree_maze_q_learning_step.sv @@
// ----------------------------------------------------------------------------
// tree_maze_q_learning_step: tabular q-learning step engine on a binary tree
// Epsilon-greedy child choice and fixed-point q update on a 15-node tree.
// ----------------------------------------------------------------------------
// A load transaction writes one q entry and goes from acceptance straight to
// its commit into the result register; a step transaction first passes
// through the pick, fetch and multiply states. No new transaction is taken
// until the last one has been committed. The length of a step is set by
// the q table's two read ports (the two children of the position, then the
// chosen node and its two children over two more reads) and by the two
// dependent multiplies of the update (alpha*gamma, then times the larger
// child q). The result sits in an output
// register, so the next transaction is taken as soon as a result has been
// committed even while that result waits for o_result.ready; a commit waits
// only while the register still holds an untaken result. Configuration writes
// are always ready and take effect on the next cycle. The q table resets to
// all zero through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module tree_maze_q_learning_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmq_chan_if.sink    i_item,
    tmq_chan_if.source  o_result,
    tmq_chan_if.sink    i_cfg
);

    tmq_pkg::t_dp_cmd    dp_cmd;
    tmq_pkg::t_dp_status dp_status;
    tmq_pkg::t_out_item  dp_result;
    logic                out_valid;
    logic                item_ready;

    // register writes never stall
    assign i_cfg.ready = 1'b1;

    // sequencer: one transaction in flight, result register handshake
    tmq_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_result.ready),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd)
    );

    // q table, position, registers and update arithmetic
    tmq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_item_data   (i_item.data),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_result_data (dp_result)
    );

    assign i_item.ready   = item_ready;
    assign o_result.valid = out_valid;
    assign o_result.data  = dp_result;

    // the sequencer drives at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("more than one datapath command active");

    // the position never leaves the inner nodes
    a_pos_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !dp_status.pos_bad)
        else $error("position left the inner nodes");

    // a commit never overwrites a result that has not been taken
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten");

    // after a transaction is accepted the block is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("transaction accepted while another is in flight");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tree maze q-learning step engine
// A queue-fed driver offers load and step transactions while a clocked monitor
// mirrors the q table, position and registers to predict every result and
// checks each one in order. Phases change the register settings and the
// idling pattern on both channels, and one phase holds off the result side
// long enough to back up the engine and stall its input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOLD_LEN      = 200;   // long result hold-off in cycles
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned SETTLE_CYCLES = 8;     // a bit over one step transaction
    localparam int unsigned PHASE_ITEMS   = 150;
    localparam logic [tmq_pkg::CFG_IDX_W-1:0] CFG_BEYOND_LAST =
        tmq_pkg::CFG_IDX_W'(tmq_pkg::CFG_GOAL_REWARD + 1);

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk;
    logic i_rst_n;

    tmq_chan_if #(.t_payload(tmq_pkg::t_in_item))   item_if ();
    tmq_chan_if #(.t_payload(tmq_pkg::t_out_item))  result_if ();
    tmq_chan_if #(.t_payload(tmq_pkg::t_cfg_write)) cfg_if ();

    tree_maze_q_learning_step u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // mirror of the engine state, updated as transactions are accepted
    tmq_pkg::t_q                q_mirror [tmq_pkg::NODE_COUNT];
    tmq_pkg::t_node             pos_mirror;
    logic [tmq_pkg::FRAC_W-1:0] alpha_mirror;
    logic [tmq_pkg::FRAC_W-1:0] gamma_mirror;
    logic [tmq_pkg::FRAC_W:0]   explore_thr_mirror;
    tmq_pkg::t_node             goal_mirror;
    tmq_pkg::t_q                reward_mirror;

    tmq_pkg::t_in_item    item_backlog[$];      // transactions waiting for the driver
    tmq_pkg::t_out_item   awaited_results[$];   // predicted results, oldest first
    int unsigned n_pushed;
    int unsigned n_accepted;
    int unsigned n_errors;

    t_idle_mode  idle_mode;
    logic        item_taken;           // item handshake seen at the last rising edge
    logic        pressure_on;
    int unsigned hold_cnt;

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // one load or step against the mirror; returns the result it must produce
    function automatic tmq_pkg::t_out_item apply_q_transaction(tmq_pkg::t_in_item it);
        tmq_pkg::t_out_item r;
        int unsigned        lft;
        int unsigned        rgt;
        int unsigned        nd;
        longint unsigned    q;
        longint unsigned    qmax;
        r = '0;
        if (it.op == tmq_pkg::OP_LOAD) begin
            r.chosen_node = it.load_index;
            // an index past the table writes nothing and reports zero
            if (it.load_index < tmq_pkg::NODE_COUNT) begin
                q_mirror[it.load_index] = it.load_value;
                r.new_value = it.load_value;
            end
        end else begin
            lft = 2 * pos_mirror + 1;
            rgt = lft + 1;
            if (pos_mirror >= tmq_pkg::FIRST_LEAF || rgt >= tmq_pkg::NODE_COUNT) begin
                // position with no children: back to the root as at a leaf
                r.episode_end = 1'b1;
                pos_mirror    = '0;
            end else begin
                if (it.explore_draw < explore_thr_mirror) begin
                    r.explored = 1'b1;
                    nd = it.branch_draw ? rgt : lft;
                end else begin
                    // greedy, ties go right
                    nd = (q_mirror[lft] > q_mirror[rgt]) ? lft : rgt;
                end
                q = q_mirror[nd];
                if (nd >= tmq_pkg::FIRST_LEAF) begin
                    // only the goal leaf moves, toward the reward
                    if (nd == goal_mirror)
                        q = (q * (256 - alpha_mirror) + alpha_mirror * reward_mirror) >> 8;
                end else begin
                    qmax = (q_mirror[2*nd+1] > q_mirror[2*nd+2]) ? q_mirror[2*nd+1]
                                                                   : q_mirror[2*nd+2];
                    q = (q * (65536 - 256 * alpha_mirror)
                         + alpha_mirror * gamma_mirror * qmax) >> 16;
                end
                q_mirror[nd]  = tmq_pkg::t_q'(q);
                r.chosen_node = tmq_pkg::t_node'(nd);
                r.new_value   = tmq_pkg::t_q'(q);
                if (nd >= tmq_pkg::FIRST_LEAF) begin
                    r.episode_end = 1'b1;
                    pos_mirror    = '0;
                end else begin
                    pos_mirror = tmq_pkg::t_node'(nd);
                end
            end
        end
        return r;
    endfunction

    // register write into the mirror; unknown indexes are dropped
    function automatic void apply_register_write(tmq_pkg::t_cfg_write w);
        case (w.index)
            tmq_pkg::CFG_LEARN_RATE:
                alpha_mirror       = w.value[tmq_pkg::FRAC_W-1:0];
            tmq_pkg::CFG_DISCOUNT:
                gamma_mirror       = w.value[tmq_pkg::FRAC_W-1:0];
            tmq_pkg::CFG_EXPLORE_THRESHOLD:
                explore_thr_mirror = w.value[tmq_pkg::FRAC_W:0];
            tmq_pkg::CFG_GOAL_NODE:
                goal_mirror        = w.value[tmq_pkg::NODE_W-1:0];
            tmq_pkg::CFG_GOAL_REWARD:
                reward_mirror      = w.value[tmq_pkg::Q_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // monitor and scoreboard: everything sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        tmq_pkg::t_out_item want;
        tmq_pkg::t_out_item got;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= item_if.valid && item_if.ready;
            // results first: a result never belongs to an item taken on the same edge
            if (result_if.valid && result_if.ready) begin
                got = result_if.data;
                if (awaited_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result node %0d value %0d explored %0b end %0b",
                                 $realtime, got.chosen_node, got.new_value, got.explored,
                                 got.episode_end);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.chosen_node !== want.chosen_node || got.new_value !== want.new_value
                        || got.explored !== want.explored
                        || got.episode_end !== want.episode_end) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: result node %0d value %0d explored %0b end %0b, %s",
                                     $realtime, got.chosen_node, got.new_value, got.explored,
                                     got.episode_end,
                                     $sformatf("expected node %0d value %0d explored %0b end %0b",
                                               want.chosen_node, want.new_value,
                                               want.explored, want.episode_end));
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                apply_register_write(cfg_if.data);
            if (item_if.valid && item_if.ready) begin
                awaited_results.push_back(apply_q_transaction(item_if.data));
                n_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // item driver: changes at the falling edge, holds until taken
    // ------------------------------------------------------------------------
    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SRC:  return $urandom_range(99) < 80;
            IDLE_BOTH: return $urandom_range(99) < 22;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_SNK:  return $urandom_range(99) < 80;
            IDLE_BOTH: return $urandom_range(99) < 22;
            default:   return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (item_if.valid && !item_taken) begin
            // offered but not yet taken: keep it steady
        end else if (item_backlog.size() != 0 && !sender_rests()) begin
            item_if.valid <= 1'b1;
            item_if.data  <= item_backlog.pop_front();
        end else begin
            item_if.valid <= 1'b0;
        end
    end

    // result side ready, with the long hold-off when pressure is on
    always @(negedge i_clk) begin
        if (pressure_on && hold_cnt < HOLD_LEN)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= !receiver_stalls();
    end

    // hold-off length counted here, apart from the ready process
    always @(posedge i_clk) begin
        if (!pressure_on)
            hold_cnt <= 0;
        else if (hold_cnt < HOLD_LEN)
            hold_cnt <= hold_cnt + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic tmq_pkg::t_in_item load_item(int unsigned idx, int unsigned val);
        tmq_pkg::t_in_item it;
        it.op           = tmq_pkg::OP_LOAD;
        it.load_index   = tmq_pkg::t_node'(idx);
        it.load_value   = tmq_pkg::t_q'(val);
        it.explore_draw = tmq_pkg::FRAC_W'($urandom_range(255));   // ignored by a load
        it.branch_draw  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic tmq_pkg::t_in_item step_item(int unsigned draw, int unsigned branch);
        tmq_pkg::t_in_item it;
        it.op           = tmq_pkg::OP_STEP;
        it.load_index   = tmq_pkg::t_node'($urandom_range(15));    // ignored by a step
        it.load_value   = tmq_pkg::t_q'($urandom_range(1023));
        it.explore_draw = tmq_pkg::FRAC_W'(draw);
        it.branch_draw  = 1'(branch);
        return it;
    endfunction

    // mostly steps so episodes run deep, loads reshape the table along the way
    function automatic tmq_pkg::t_in_item random_transaction();
        int unsigned idx;
        int unsigned val;
        if ($urandom_range(99) < 20) begin
            idx = ($urandom_range(19) == 0) ? tmq_pkg::NODE_COUNT
                                            : $urandom_range(tmq_pkg::NODE_COUNT - 1);
            // a few fixed values make sibling ties common
            case ($urandom_range(3))
                0:       val = 0;
                1:       val = 1023;
                2:       val = 512;
                default: val = $urandom_range(1023);
            endcase
            return load_item(idx, val);
        end
        return step_item($urandom_range(255), $urandom_range(1));
    endfunction

    task automatic queue_item(input tmq_pkg::t_in_item it);
        item_backlog.push_back(it);
        n_pushed++;
    endtask

    task automatic write_register(input logic [tmq_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned val);
        @(negedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= idx;
        cfg_if.data.value <= tmq_pkg::CFG_VAL_W'(val);
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic program_settings(input int unsigned alpha, input int unsigned gamma,
                                    input int unsigned thr, input int unsigned goal,
                                    input int unsigned reward);
        write_register(tmq_pkg::CFG_LEARN_RATE, alpha);
        write_register(tmq_pkg::CFG_DISCOUNT, gamma);
        write_register(tmq_pkg::CFG_EXPLORE_THRESHOLD, thr);
        write_register(tmq_pkg::CFG_GOAL_NODE, goal);
        write_register(tmq_pkg::CFG_GOAL_REWARD, reward);
    endtask

    // every transaction accepted and answered, then a few quiet cycles
    task automatic wait_for_idle();
        while (n_accepted != n_pushed || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input t_idle_mode mode, input bit squeeze, input int unsigned count);
        idle_mode   = mode;
        pressure_on = squeeze;
        repeat (count) queue_item(random_transaction());
        wait_for_idle();
        pressure_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        idle_mode       = IDLE_NONE;
        pressure_on     = 1'b0;
        n_pushed        = 0;
        n_accepted      = 0;
        n_errors        = 0;
        foreach (q_mirror[k]) q_mirror[k] = '0;
        pos_mirror         = '0;
        alpha_mirror       = tmq_pkg::RST_LEARN_RATE;
        gamma_mirror       = tmq_pkg::RST_DISCOUNT;
        explore_thr_mirror = tmq_pkg::RST_EXPLORE_THR;
        goal_mirror        = tmq_pkg::RST_GOAL_NODE;
        reward_mirror      = tmq_pkg::RST_GOAL_REWARD;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset settings
        queue_item(load_item(0, 1023));
        queue_item(load_item(1, 0));
        queue_item(load_item(2, 1023));
        queue_item(load_item(tmq_pkg::NODE_COUNT, 1023));   // past the table: no write
        queue_item(load_item(14, 500));
        queue_item(load_item(6, 300));
        queue_item(step_item(255, 0));   // greedy, right child larger
        queue_item(step_item(77, 1));    // draw equal to threshold stays greedy
        queue_item(step_item(76, 1));    // explore right onto the goal leaf
        queue_item(step_item(0, 0));     // explore left
        queue_item(step_item(0, 1));
        queue_item(step_item(200, 0));   // tie between leaves goes right, no reward
        queue_item(load_item(13, 1023));
        queue_item(load_item(14, 0));
        queue_item(load_item(6, 0));
        queue_item(step_item(255, 1));
        queue_item(step_item(255, 1));
        queue_item(step_item(255, 1));   // left leaf larger: greedy goes left
        queue_item(load_item(7, 1023));
        queue_item(step_item(0, 0));
        queue_item(step_item(0, 0));
        queue_item(step_item(0, 0));     // leftmost leaf at full scale
        wait_for_idle();

        // random part, one setting per phase
        program_settings($urandom_range(1023), $urandom_range(1023), $urandom_range(511),
                         $urandom_range(15), $urandom_range(1023));
        run_phase(IDLE_NONE, 1'b1, PHASE_ITEMS);   // long result hold-off

        program_settings(255, 255, 0, 14, 1023);   // never explores, largest rates
        run_phase(IDLE_SRC, 1'b0, PHASE_ITEMS);

        program_settings(0, 0, 256, 7, 0);         // always explores, frozen table
        run_phase(IDLE_SNK, 1'b0, PHASE_ITEMS);

        program_settings(128, 200, 511, 3, 777);   // goal on an inner node
        run_phase(IDLE_BOTH, 1'b0, PHASE_ITEMS);

        program_settings($urandom_range(255), $urandom_range(255), 300, 15,
                         $urandom_range(1023));    // goal past the table
        run_phase(IDLE_NONE, 1'b0, PHASE_ITEMS);

        program_settings($urandom_range(255), $urandom_range(255), $urandom_range(256),
                         0, $urandom_range(1023)); // goal at the root
        run_phase(IDLE_SRC, 1'b0, PHASE_ITEMS);

        // writes to unused indexes must leave the settings alone
        program_settings($urandom_range(1023), $urandom_range(1023), $urandom_range(511),
                         7 + $urandom_range(7), $urandom_range(1023));
        for (int k = CFG_BEYOND_LAST; k < 2**tmq_pkg::CFG_IDX_W; k++)
            write_register(tmq_pkg::CFG_IDX_W'(k), $urandom_range(1023));
        run_phase(IDLE_SNK, 1'b0, PHASE_ITEMS);

        program_settings($urandom_range(1023), $urandom_range(1023), $urandom_range(511),
                         7 + $urandom_range(7), $urandom_range(1023));
        run_phase(IDLE_BOTH, 1'b0, PHASE_ITEMS);

        if (n_errors == 0 && awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
